// ===== rtl/polynomial_bank_evaluator_core_assert.svh =====
// assertion macros shared by the polynomial bank evaluator rtl
`ifndef POLYNOMIAL_BANK_EVALUATOR_CORE_ASSERT_SVH
`define POLYNOMIAL_BANK_EVALUATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge out of reset
`define PBE_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// same-cycle implication
`define PBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PBE_ASSERT(label, expr, msg)
`define PBE_ASSERT_IMPL(label, ante, cons, msg)
`define PBE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/pbe_pkg.sv =====
// types, codes and saturation helpers for the polynomial bank evaluator
`timescale 1ns / 1ps

package pbe_pkg;

    // q16.16 data format
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic signed [PROD_W-1:0] q_prod_t;
    typedef logic [2:0]               poly_sel_t;
    typedef logic [3:0]               term_sel_t;
    typedef logic [3:0]               poly_cnt_t;
    typedef logic [4:0]               term_cnt_t;
    typedef logic [0:0]               cfg_idx_t;
    typedef logic [4:0]               cfg_data_t;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // configuration register indexes
    localparam cfg_idx_t REG_POLY_COUNT = 1'b0;
    localparam cfg_idx_t REG_TERM_COUNT = 1'b1;

    localparam q16_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q16_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        q16_t value;
        logic sat;
    } sat_res_t;

    // arithmetic shift of a full product by FRAC_W, clamped to 32 bits
    function automatic sat_res_t sat_product(input q_prod_t prod);
        sat_res_t res;
        logic     fits;
        fits = (prod[PROD_W-1:FRAC_W+DATA_W-1] == '0) ||
               (prod[PROD_W-1:FRAC_W+DATA_W-1] == '1);
        if (fits) begin
            res.value = prod[FRAC_W+DATA_W-1:FRAC_W];
            res.sat   = 1'b0;
        end else begin
            res.value = prod[PROD_W-1] ? Q_MIN : Q_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

    // 32-bit signed add clamped to 32 bits
    function automatic sat_res_t sat_sum(input q16_t a, input q16_t b);
        sat_res_t                res;
        logic signed [DATA_W:0]  sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] == sum[DATA_W-1]) begin
            res.value = sum[DATA_W-1:0];
            res.sat   = 1'b0;
        end else begin
            res.value = sum[DATA_W] ? Q_MIN : Q_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/polynomial_bank_evaluator_core.sv =====
// Polynomial bank evaluator top level. A bank of up to MAX_POLYS polynomials of up to
// MAX_TERMS q16.16 coefficients each sits in one ram, highest power first. A write request
// stores one coefficient and gives no result; an evaluate request runs Horner's rule for
// every polynomial in use, one shared 32x32 multiplier and saturating adder stepping through
// the coefficients, and sends one result per polynomial, the last marked. Each Horner step
// is a multiply, a shift and clamp, and an add and clamp, and output backpressure can hold
// an evaluate request before it sends each result. After reset a clearing pass zeroes the
// ram one entry per cycle, during which no request is taken; configuration writes are
// taken at any time.
`timescale 1ns / 1ps
`include "polynomial_bank_evaluator_core_assert.svh"

module polynomial_bank_evaluator_core #(
    parameter int MAX_POLYS = 8,
    parameter int MAX_TERMS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_wr_en,
    input  pbe_pkg::cfg_idx_t   cfg_index,
    input  pbe_pkg::cfg_data_t  cfg_wr_data,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  pbe_pkg::poly_sel_t  s_poly_select,
    input  pbe_pkg::term_sel_t  s_term_select,
    input  pbe_pkg::q16_t       s_coef_value,
    input  pbe_pkg::q16_t       s_x_value,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output pbe_pkg::poly_sel_t  m_poly_number,
    output pbe_pkg::q16_t       m_poly_value,
    output logic                m_saturated,
    output logic                m_last_result
);

    import pbe_pkg::*;

    localparam int DEPTH  = MAX_POLYS * MAX_TERMS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NP_W   = $clog2(MAX_POLYS + 1);
    localparam int NT_W   = $clog2(MAX_TERMS + 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SAT   = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [NT_W-1:0]   term_reg, term_next;
    logic [NP_W-1:0]   poly_reg, poly_next;
    logic [NP_W-1:0]   np_reg, np_next;
    logic [NT_W-1:0]   nt_reg, nt_next;
    q16_t              x_reg, x_next;
    q16_t              acc_reg, acc_next;
    q_prod_t           prod_reg, prod_next;
    logic              sat_reg, sat_next;
    poly_cnt_t         poly_count_reg, poly_count_next;
    term_cnt_t         term_count_reg, term_count_next;

    logic              m_valid_reg, m_valid_next;
    poly_sel_t         m_poly_number_reg, m_poly_number_next;
    q16_t              m_poly_value_reg, m_poly_value_next;
    logic              m_saturated_reg, m_saturated_next;
    logic              m_last_result_reg, m_last_result_next;

    logic              s_fire;
    logic              wr_in_range;
    logic              out_free;
    logic              poly_last;
    logic [NT_W-1:0]   term_inc;
    logic [NP_W-1:0]   np_clamped;
    logic [NT_W-1:0]   nt_clamped;
    sat_res_t          prod_sat;
    sat_res_t          add_sat;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // coefficient store
    pbe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // handshake and helpers
    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign wr_in_range = (32'(s_poly_select) < MAX_POLYS) && (32'(s_term_select) < MAX_TERMS);
    assign term_inc    = term_reg + NT_W'(1);
    assign poly_last   = ({1'b0, poly_reg} + (NP_W+1)'(1)) == {1'b0, np_reg};
    assign ram_rd_addr = base_reg + ADDR_W'(term_reg);
    assign prod_sat    = sat_product(prod_reg);
    assign add_sat     = sat_sum(acc_reg, $signed(ram_rd_data));

    // count registers: zero acts as one, too large acts as the bank size
    always_comb begin
        if (poly_count_reg == '0) begin
            np_clamped = NP_W'(1);
        end else if (32'(poly_count_reg) > MAX_POLYS) begin
            np_clamped = NP_W'(MAX_POLYS);
        end else begin
            np_clamped = NP_W'(poly_count_reg);
        end
        if (term_count_reg == '0) begin
            nt_clamped = NT_W'(1);
        end else if (32'(term_count_reg) > MAX_TERMS) begin
            nt_clamped = NT_W'(MAX_TERMS);
        end else begin
            nt_clamped = NT_W'(term_count_reg);
        end
    end

    // ram write port: clearing pass or coefficient write
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = base_reg;
        ram_wr_data = '0;
        if (state_reg == S_CLEAR) begin
            ram_wr_en = 1'b1;
        end else if (s_fire && (s_req_type == REQ_WRITE) && wr_in_range) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(32'(s_poly_select) * MAX_TERMS + 32'(s_term_select));
            ram_wr_data = s_coef_value;
        end
    end

    // configuration registers
    always_comb begin
        poly_count_next = poly_count_reg;
        term_count_next = term_count_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLY_COUNT: poly_count_next = cfg_wr_data[3:0];
                REG_TERM_COUNT: term_count_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    // horner sequencer
    always_comb begin
        state_next         = state_reg;
        base_next          = base_reg;
        term_next          = term_reg;
        poly_next          = poly_reg;
        np_next            = np_reg;
        nt_next            = nt_reg;
        x_next             = x_reg;
        acc_next           = acc_reg;
        prod_next          = prod_reg;
        sat_next           = sat_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_poly_number_next = m_poly_number_reg;
        m_poly_value_next  = m_poly_value_reg;
        m_saturated_next   = m_saturated_reg;
        m_last_result_next = m_last_result_reg;

        case (state_reg)
            S_CLEAR: begin
                if (base_reg == ADDR_W'(DEPTH - 1)) begin
                    base_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    base_next = base_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_fire && (s_req_type == REQ_EVAL)) begin
                    x_next     = s_x_value;
                    np_next    = np_clamped;
                    nt_next    = nt_clamped;
                    base_next  = '0;
                    term_next  = '0;
                    poly_next  = '0;
                    state_next = S_READ;
                end
            end
            // wait out the ram read latency for the leading coefficient
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                acc_next  = $signed(ram_rd_data);
                sat_next  = 1'b0;
                term_next = term_inc;
                if (term_inc == nt_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'(x_reg);
                state_next = S_SAT;
            end
            S_SAT: begin
                acc_next   = prod_sat.value;
                sat_next   = sat_reg | prod_sat.sat;
                state_next = S_ADD;
            end
            S_ADD: begin
                acc_next  = add_sat.value;
                sat_next  = sat_reg | add_sat.sat;
                term_next = term_inc;
                if (term_inc == nt_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_poly_number_next = 3'(poly_reg);
                    m_poly_value_next  = acc_reg;
                    m_saturated_next   = sat_reg;
                    m_last_result_next = poly_last;
                    if (poly_last) begin
                        base_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        poly_next  = poly_reg + NP_W'(1);
                        base_next  = base_reg + ADDR_W'(MAX_TERMS);
                        term_next  = '0;
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            base_reg       <= '0;
            term_reg       <= '0;
            poly_reg       <= '0;
            np_reg         <= NP_W'(1);
            nt_reg         <= NT_W'(1);
            poly_count_reg <= 4'd1;
            term_count_reg <= 5'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            term_reg       <= term_next;
            poly_reg       <= poly_next;
            np_reg         <= np_next;
            nt_reg         <= nt_next;
            poly_count_reg <= poly_count_next;
            term_count_reg <= term_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath and result payload registers
    always_ff @(posedge aclk) begin
        x_reg             <= x_next;
        acc_reg           <= acc_next;
        prod_reg          <= prod_next;
        sat_reg           <= sat_next;
        m_poly_number_reg <= m_poly_number_next;
        m_poly_value_reg  <= m_poly_value_next;
        m_saturated_reg   <= m_saturated_next;
        m_last_result_reg <= m_last_result_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_poly_number = m_poly_number_reg;
    assign m_poly_value  = m_poly_value_reg;
    assign m_saturated   = m_saturated_reg;
    assign m_last_result = m_last_result_reg;

    // checks on the sequencer
    `PBE_ASSERT_IMPL(a_no_write_while_busy, (state_reg != S_IDLE) && (state_reg != S_CLEAR), !ram_wr_en, "coefficient write during evaluation")
    `PBE_ASSERT_IMPL(a_term_in_range, (state_reg == S_MUL) || (state_reg == S_SAT) || (state_reg == S_ADD), (term_reg != '0) && (term_reg < nt_reg), "horner step index out of range")
    `PBE_ASSERT_IMPL(a_poly_in_range, (state_reg != S_IDLE) && (state_reg != S_CLEAR), poly_reg < np_reg, "polynomial index beyond count in use")
    `PBE_ASSERT_NEXT(a_last_ends_eval, (state_reg == S_EMIT) && out_free && poly_last, (state_reg == S_IDLE) && m_valid_reg && m_last_result_reg, "last result did not end the evaluation")

endmodule

// ===== rtl/pbe_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module pbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
